### rtl/mqtt_header_field_extractor_core_defines.svh
// assertion macros used by the checker file
`ifndef MQTT_HEADER_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define MQTT_HEADER_FIELD_EXTRACTOR_CORE_DEFINES_SVH

// property sampled on clk_i, off while rst_ni is low
`define MQTTHFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MQTTHFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mqtthfe_pkg.sv
package mqtthfe_pkg;

  // parse phase within a segment
  typedef enum logic [1:0] {
    PH_HEAD,
    PH_LEN,
    PH_BODY,
    PH_DONE
  } phase_e;

  // flow action reported at segment end
  typedef enum logic [1:0] {
    ACT_KEEP   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FLUSH  = 2'd2
  } act_e;

  // protocol label matcher state
  typedef enum logic [2:0] {
    LAB_HDR,
    LAB_LEN,
    LAB_STR,
    LAB_YES,
    LAB_NO
  } label_e;

  // control packet type codes
  localparam logic [3:0] PKT_CONNECT    = 4'd1;
  localparam logic [3:0] PKT_CONNACK    = 4'd2;
  localparam logic [3:0] PKT_PUBLISH    = 4'd3;
  localparam logic [3:0] PKT_DISCONNECT = 4'd14;

  localparam logic [7:0] HASH_CHAR = 8'h23;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       segment_start;
    logic       segment_end;
    logic       new_flow;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  flow_action;
    logic [15:0] types_seen;
    logic [7:0]  protocol_version;
    logic [7:0]  connect_flags;
    logic [15:0] keep_alive;
    logic [7:0]  connack_code;
    logic [3:0]  publish_flags;
    logic [5:0]  fields_present;
  } out_word_t;

  // controls from the parser to the label matcher
  typedef struct packed {
    logic seg_start;
    logic take;
    logic seg_end;
  } lab_ctl_t;

endpackage

### rtl/mqtthfe_label.sv
module mqtthfe_label (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mqtthfe_pkg::lab_ctl_t ctl_i,
  input  logic [7:0]            data_byte_i,
  output logic                  label_yes_o
);
  import mqtthfe_pkg::*;

  label_e     lab_q, lab_d, lab_cur, lab_nxt;
  logic [2:0] cnt_q, cnt_d, cnt_cur, cnt_nxt;
  logic [7:0] exp_byte;
  logic       exp_ok;

  // expected label byte: 00 04 'M' 'Q' 'T' 'T'
  always_comb begin
    exp_ok = 1'b1;
    case (cnt_cur)
      3'd0:    exp_byte = 8'h00;
      3'd1:    exp_byte = 8'h04;
      3'd2:    exp_byte = 8'h4D;
      3'd3:    exp_byte = 8'h51;
      3'd4:    exp_byte = 8'h54;
      3'd5:    exp_byte = 8'h54;
      default: begin
        exp_byte = 8'h00;
        exp_ok   = 1'b0;
      end
    endcase
  end

  // segment start restarts the match
  assign lab_cur = ctl_i.seg_start ? LAB_HDR : lab_q;
  assign cnt_cur = ctl_i.seg_start ? 3'd0 : cnt_q;

  // next state
  always_comb begin
    lab_nxt = lab_cur;
    cnt_nxt = cnt_cur;
    if (ctl_i.take) begin
      unique case (lab_cur)
        LAB_HDR: begin
          lab_nxt = LAB_LEN;
          cnt_nxt = 3'd0;
        end
        LAB_LEN: begin
          cnt_nxt = cnt_cur + 3'd1;
          if (!data_byte_i[7]) begin
            lab_nxt = LAB_STR;
            cnt_nxt = 3'd0;
          end else if (cnt_nxt >= 3'd4) begin
            lab_nxt = LAB_NO;
          end
        end
        LAB_STR: begin
          if (!exp_ok || data_byte_i != exp_byte) begin
            lab_nxt = LAB_NO;
          end else begin
            cnt_nxt = cnt_cur + 3'd1;
            if (cnt_nxt == 3'd6) begin
              lab_nxt = LAB_YES;
            end
          end
        end
        LAB_YES, LAB_NO: begin
          lab_nxt = lab_cur;
        end
        default: begin
          lab_nxt = LAB_NO;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    label_yes_o = (lab_nxt == LAB_YES);
    lab_d       = ctl_i.seg_end ? LAB_HDR : lab_nxt;
    cnt_d       = ctl_i.seg_end ? 3'd0 : cnt_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lab_q <= LAB_HDR;
      cnt_q <= 3'd0;
    end else begin
      lab_q <= lab_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/mqtt_header_field_extractor_core.sv
// Path: a word taken into the input register passes one parse stage into the result register.
// Throughput: one word per cycle; the single parse stage updates all segment and flow state.
// A stalled result holds only words that end a segment; other words keep flowing.
// Reset (rst_ni low, asynchronous): segment state at packet header, flow fields zero, no result.
module mqtt_header_field_extractor_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mqtthfe_pkg::in_word_t  in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mqtthfe_pkg::out_word_t out_word_o
);
  import mqtthfe_pkg::*;

  localparam int unsigned SumW = ((OFFSET_BITS > 28) ? OFFSET_BITS : 28) + 1;

  // per-segment parse state
  typedef struct packed {
    phase_e                 phase;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] pend;
    logic [27:0]            acc;
    logic [2:0]             lcnt;
    logic [3:0]             ptype;
    logic [3:0]             pflags;
    logic [15:0]            topic;
    act_e                   verdict;
    logic [3:0]             bpos;
    logic                   need_label;
    logic [7:0]             version;
    logic [7:0]             cflags;
    logic [15:0]            keep;
    logic                   session;
    logic [7:0]             code;
    logic                   topic_bad;
  } seg_t;

  // per-flow summary fields
  typedef struct packed {
    logic [15:0] types;
    logic [7:0]  version;
    logic [7:0]  cflags;
    logic [15:0] keep;
    logic [7:0]  code;
    logic [3:0]  pub;
    logic [5:0]  present;
  } flow_t;

  logic      in_valid_q, in_valid_d;
  in_word_t  in_word_q;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;
  out_word_t res_word;
  seg_t      seg_q, seg_mid, seg_d;
  flow_t     flow_q, flow_mid, flow_end, flow_d;
  act_e      act;
  logic      out_free, fire, in_take, res_valid;
  logic      start_now, take_now, end_now;
  logic      label_yes;
  lab_ctl_t  lab_ctl;

  // handshake: input register feeds the parse stage, result register drains it
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = in_valid_q && (!in_word_q.segment_end || out_free);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take   = in_valid_i && !in_stall_o;
  assign res_valid = fire && in_word_q.segment_end;
  assign in_valid_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = res_valid ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  assign start_now = fire && in_word_q.segment_start;
  assign take_now  = fire && in_word_q.byte_valid;
  assign end_now   = res_valid;

  // label matcher sees a byte only when the segment offset has room
  assign lab_ctl.seg_start = start_now;
  assign lab_ctl.take      = take_now && (start_now || !(&seg_q.offset));
  assign lab_ctl.seg_end   = end_now;

  mqtthfe_label u_label (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (lab_ctl),
    .data_byte_i (in_word_q.data_byte),
    .label_yes_o (label_yes)
  );

  // segment start, byte parse and packet commit
  always_comb begin : parse_next
    logic [SumW-1:0] sum;
    logic [15:0]     tl;
    logic [7:0]      b;
    logic            done_pkt;
    act_e            v;

    seg_mid  = seg_q;
    flow_mid = flow_q;
    sum      = '0;
    tl       = '0;
    b        = in_word_q.data_byte;
    done_pkt = 1'b0;
    v        = ACT_KEEP;

    if (start_now) begin
      seg_mid = '0;
      if (in_word_q.new_flow) begin
        flow_mid           = '0;
        seg_mid.need_label = 1'b1;
      end
    end

    if (take_now) begin
      if (&seg_mid.offset) begin
        seg_mid.verdict = ACT_REMOVE;
        seg_mid.phase   = PH_DONE;
      end else begin
        seg_mid.offset = seg_mid.offset + OFFSET_BITS'(1);
        unique case (seg_mid.phase)
          PH_HEAD: begin
            seg_mid.ptype          = b[7:4];
            seg_mid.pflags         = b[3:0];
            flow_mid.types[b[7:4]] = 1'b1;
            flow_mid.present[0]    = 1'b1;
            seg_mid.acc            = '0;
            seg_mid.lcnt           = 3'd0;
            seg_mid.phase          = PH_LEN;
          end
          PH_LEN: begin
            // remaining length, 7 bits per byte, low group first
            case (seg_mid.lcnt[1:0])
              2'd0:    seg_mid.acc[6:0]   = seg_mid.acc[6:0] | b[6:0];
              2'd1:    seg_mid.acc[13:7]  = seg_mid.acc[13:7] | b[6:0];
              2'd2:    seg_mid.acc[20:14] = seg_mid.acc[20:14] | b[6:0];
              default: seg_mid.acc[27:21] = seg_mid.acc[27:21] | b[6:0];
            endcase
            seg_mid.lcnt = seg_mid.lcnt + 3'd1;
            if (!b[7]) begin
              // body start: packet must end inside the offset range
              sum = SumW'(seg_mid.offset) + SumW'(seg_mid.acc);
              if (|sum[SumW-1:OFFSET_BITS]) begin
                seg_mid.verdict = ACT_REMOVE;
                seg_mid.phase   = PH_DONE;
              end else begin
                seg_mid.pend      = sum[OFFSET_BITS-1:0];
                seg_mid.bpos      = 4'd0;
                seg_mid.topic     = '0;
                seg_mid.version   = '0;
                seg_mid.cflags    = '0;
                seg_mid.keep      = '0;
                seg_mid.session   = 1'b0;
                seg_mid.code      = '0;
                seg_mid.topic_bad = (seg_mid.ptype == PKT_PUBLISH) &&
                                    (seg_mid.acc < 28'd2);
                seg_mid.phase     = PH_BODY;
                done_pkt          = (seg_mid.acc == '0);
              end
            end else if (seg_mid.lcnt >= 3'd4) begin
              seg_mid.verdict = ACT_REMOVE;
              seg_mid.phase   = PH_DONE;
            end
          end
          PH_BODY: begin
            case (seg_mid.ptype)
              PKT_CONNECT: begin
                case (seg_mid.bpos)
                  4'd6:    seg_mid.version   = b;
                  4'd7:    seg_mid.cflags    = b;
                  4'd8:    seg_mid.keep      = {b, 8'h00};
                  4'd9:    seg_mid.keep[7:0] = b;
                  default: ;
                endcase
              end
              PKT_CONNACK: begin
                if (seg_mid.bpos == 4'd0) begin
                  seg_mid.session = b[0];
                end else if (seg_mid.bpos == 4'd1) begin
                  seg_mid.code = b;
                end
              end
              PKT_PUBLISH: begin
                if (seg_mid.bpos == 4'd0) begin
                  seg_mid.topic = {b, 8'h00};
                end else if (seg_mid.bpos == 4'd1) begin
                  tl = {seg_mid.topic[15:8], b};
                  // topic length field plus topic must fit the packet
                  if (28'(tl) + 28'd2 > seg_mid.acc) begin
                    seg_mid.topic_bad = 1'b1;
                    seg_mid.topic     = '0;
                  end else begin
                    seg_mid.topic = tl;
                  end
                end else if (seg_mid.topic != '0) begin
                  if (b == HASH_CHAR) begin
                    seg_mid.topic_bad = 1'b1;
                  end
                  seg_mid.topic = seg_mid.topic - 16'd1;
                end
              end
              default: ;
            endcase
            if (seg_mid.bpos != 4'd15) begin
              seg_mid.bpos = seg_mid.bpos + 4'd1;
            end
            done_pkt = (seg_mid.offset == seg_mid.pend);
          end
          PH_DONE: ;
        endcase
      end
    end

    // packet commit on its last byte
    if (done_pkt) begin
      case (seg_mid.ptype)
        PKT_CONNECT: begin
          if (!label_yes || seg_mid.acc < 28'd10) begin
            v = ACT_REMOVE;
          end else begin
            flow_mid.version    = seg_mid.version;
            flow_mid.present[1] = 1'b1;
            if (seg_mid.version != 8'd4 && seg_mid.version != 8'd5) begin
              v = ACT_REMOVE;
            end else begin
              flow_mid.cflags       = seg_mid.cflags;
              flow_mid.keep         = seg_mid.keep;
              flow_mid.present[3:2] = 2'b11;
            end
          end
        end
        PKT_CONNACK: begin
          if (seg_mid.acc < 28'd2) begin
            v = ACT_REMOVE;
          end else begin
            flow_mid.types[0]   = flow_mid.types[0] | seg_mid.session;
            flow_mid.code       = seg_mid.code;
            flow_mid.present[4] = 1'b1;
          end
        end
        PKT_PUBLISH: begin
          flow_mid.pub        = flow_mid.pub | seg_mid.pflags;
          flow_mid.present[5] = 1'b1;
          if (seg_mid.topic_bad) begin
            v = ACT_REMOVE;
          end
        end
        PKT_DISCONNECT: begin
          v = ACT_FLUSH;
        end
        default: ;
      endcase
      if (v != ACT_KEEP) begin
        seg_mid.verdict = v;
        seg_mid.phase   = PH_DONE;
      end else begin
        seg_mid.phase = PH_HEAD;
      end
    end
  end

  // segment end: flow action and result word
  always_comb begin : result_sel
    flow_end = flow_mid;
    act      = ACT_KEEP;
    if (seg_mid.offset == '0) begin
      act = ACT_REMOVE;
    end else if (seg_mid.phase == PH_LEN || seg_mid.phase == PH_BODY) begin
      act = ACT_REMOVE;
    end else if (seg_mid.phase == PH_DONE) begin
      act = seg_mid.verdict;
    end
    // new flow without the protocol label drops everything
    if (seg_mid.need_label && !label_yes) begin
      flow_end = '0;
      act      = ACT_REMOVE;
    end

    res_word.flow_action      = act;
    res_word.types_seen       = flow_end.types;
    res_word.protocol_version = flow_end.version;
    res_word.connect_flags    = flow_end.cflags;
    res_word.keep_alive       = flow_end.keep;
    res_word.connack_code     = flow_end.code;
    res_word.publish_flags    = flow_end.pub;
    res_word.fields_present   = flow_end.present;

    flow_d = end_now ? flow_end : flow_mid;
    seg_d  = end_now ? seg_t'('0) : seg_mid;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seg_q       <= '0;
      flow_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      seg_q       <= seg_d;
      flow_q      <= flow_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### rtl/mqtthfe_checker.sv
`include "mqtt_header_field_extractor_core_defines.svh"

module mqtthfe_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input mqtthfe_pkg::out_word_t out_word_o
);
  import mqtthfe_pkg::*;

  // stalled result word holds
  `MQTTHFE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "result word changed while stalled")

  // no type bits without the types present flag
  `MQTTHFE_ASSERT(a_types_present, out_valid_o && !out_word_o.fields_present[0] |-> out_word_o.types_seen == 16'h0000, "types seen without present flag")

  // fields never captured read as zero
  `MQTTHFE_ASSERT(a_fields_zero, out_valid_o |-> (out_word_o.fields_present[1] || out_word_o.protocol_version == 8'h00) && (out_word_o.fields_present[2] || out_word_o.connect_flags == 8'h00) && (out_word_o.fields_present[3] || out_word_o.keep_alive == 16'h0000) && (out_word_o.fields_present[4] || out_word_o.connack_code == 8'h00) && (out_word_o.fields_present[5] || out_word_o.publish_flags == 4'h0), "field set without present flag")

  // flush comes only from a disconnect packet
  `MQTTHFE_ASSERT(a_flush_type, out_valid_o && out_word_o.flow_action == ACT_FLUSH |-> out_word_o.types_seen[PKT_DISCONNECT], "flush without disconnect type")

endmodule

bind mqtt_header_field_extractor_core mqtthfe_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
